>>> sv/assert_macros.svh
// Assertion macros shared by the compensation block's modules.
// Depends on nothing; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ESC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ESC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/esc_pkg.sv
// Types, constants and helpers for the environmental sensor compensation block.
// Depends on nothing; used by esc_front, esc_queue, esc_back, the top level and the testbench.
package esc_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_CAL_TEMP    = 3'd0,
        REG_CAL_PRESS_A = 3'd1,
        REG_CAL_PRESS_B = 3'd2,
        REG_CAL_PRESS_C = 3'd3,
        REG_CAL_HUM     = 3'd4
    } t_reg_idx;

    localparam int QDEPTH       = 16;
    localparam int QPTR_W       = 4;
    localparam int QCNT_W       = 5;
    localparam int FRONT_STAGES = 13;
    localparam int DIV_STEPS    = 32;

    localparam logic [31:0] C_P_OFS    = 32'd64000;
    localparam logic [31:0] C_P_BASE   = 32'd1048576;
    localparam logic [31:0] C_P_SCALE  = 32'd3125;
    localparam logic [31:0] C_P_ONE    = 32'd32768;
    localparam logic [31:0] C_H_OFS    = 32'd76800;
    localparam logic [31:0] C_H_BIAS   = 32'd2097152;
    localparam logic [31:0] C_H_RND14  = 32'd16384;
    localparam logic [31:0] C_H_RND13  = 32'd8192;
    localparam logic [31:0] C_H_MAX    = 32'd419430400;

    // Calibration coefficients, each widened to a 32-bit two's complement word.
    typedef struct packed {
        logic [31:0] t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
    } t_cal;

    // One queue entry: the finished temperature and humidity, plus the
    // pressure division still to be done.
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] dvd;
        logic [31:0] dvs;
        logic        dbl;
        logic        zero;
        logic [13:0] hum;
    } t_qent;

    typedef struct packed {
        logic [13:0] hum;
        logic [31:0] temp;
    } t_pay;

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx12(input logic [11:0] x);
        return {{20{x[11]}}, x};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

endpackage

>>> sv/esc_if.sv
// Channel interfaces of the compensation block: raw input and result.
// Depends on nothing.
interface esc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;

    modport source (output valid, raw_temp, raw_press, raw_hum, input ready);
    modport sink   (input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

interface esc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temp_cdeg;
    logic        [31:0] press_pa;
    logic        [13:0] hum_crh;

    modport source (output valid, temp_cdeg, press_pa, hum_crh, input ready);
    modport sink   (input valid, temp_cdeg, press_pa, hum_crh, output ready);
endinterface

>>> sv/esc_front.sv
// Front end: accepts raw beats and runs the temperature, humidity and pressure
// set-up pipeline. Depends on esc_pkg and esc_if; uses assert_macros.svh.
`include "assert_macros.svh"

module esc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    esc_in_if.sink        i_in,
    input  esc_pkg::t_cal i_cal,
    input  logic          i_pop,
    output logic          o_push,
    output esc_pkg::t_qent o_push_data
);

    logic [esc_pkg::QCNT_W-1:0]       r_used;
    logic [esc_pkg::FRONT_STAGES-1:0] r_v;
    logic                             w_acc;

    logic [19:0] r0_at, r0_ap;
    logic [15:0] r0_ah;
    logic [31:0] w_at, w_d;
    logic [31:0] r1_m1, r1_dd;
    logic [19:0] r1_ap, r2_ap, r3_ap, r4_ap, r5_ap, r6_ap, r7_ap;
    logic [15:0] r1_ah, r2_ah, r3_ah, r4_ah, r5_ah;
    logic [31:0] r2_a, r2_bm, r3_tf;
    logic [31:0] r4_temp, r4_pa, r4_hv, w_q;
    logic [31:0] r5_sq, r5_ap5, r5_p2a, r5_h5hv, r5_h6hv, r5_h3hv, r5_temp;
    logic [31:0] r6_b1, r6_p3s, r6_x, r6_hv6, r6_hv3, r6_ap5, r6_p2a, r6_temp;
    logic [31:0] r7_b, r7_a2, r7_y1, r7_x, r7_temp;
    logic [31:0] r8_a3, r8_pn, r8_y3, r8_x, r8_temp;
    logic [31:0] r9_div, r9_pn, r9_hvm, r9_temp;
    logic [31:0] r10_ss, r10_hvm, r10_div, r10_pn, r10_temp;
    logic [31:0] r11_h1m, r11_hvm, r11_div, r11_pn, r11_temp;
    logic [31:0] w_hv, w_hvc;
    logic [23:0] w_hsc;
    esc_pkg::t_qent r12_ent;

    // Credit scheme: every beat taken owns a queue slot until it is popped,
    // so the front pipeline never has to stall.
    assign i_in.ready = (r_used < esc_pkg::QCNT_W'(esc_pkg::QDEPTH));
    assign w_acc      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_v    <= '0;
        end else begin
            r_v <= {r_v[esc_pkg::FRONT_STAGES-2:0], w_acc};
            if (w_acc && !i_pop) begin
                r_used <= r_used + 1'b1;
            end else if (!w_acc && i_pop) begin
                r_used <= r_used - 1'b1;
            end
        end
    end

    assign w_at = {12'd0, r0_at};
    assign w_d  = (w_at >> 4) - i_cal.t1;
    assign w_q  = esc_pkg::asr(r4_pa, 2);

    always_comb begin
        w_hv = r11_hvm - esc_pkg::asr(r11_h1m, 4);
        if (w_hv[31]) begin
            w_hvc = '0;
        end else if (w_hv > esc_pkg::C_H_MAX) begin
            w_hvc = esc_pkg::C_H_MAX;
        end else begin
            w_hvc = w_hv;
        end
        w_hsc = {7'd0, w_hvc[28:12]} * 24'd100 + 24'd512;
    end

    always_ff @(posedge i_clk) begin
        r0_at <= i_in.raw_temp;
        r0_ap <= i_in.raw_press;
        r0_ah <= i_in.raw_hum;
        // Temperature.
        r1_m1 <= ((w_at >> 3) - (i_cal.t1 << 1)) * i_cal.t2;
        r1_dd <= w_d * w_d;
        r1_ap <= r0_ap;
        r1_ah <= r0_ah;
        r2_a  <= esc_pkg::asr(r1_m1, 11);
        r2_bm <= esc_pkg::asr(r1_dd, 12) * i_cal.t3;
        r2_ap <= r1_ap;
        r2_ah <= r1_ah;
        r3_tf <= r2_a + esc_pkg::asr(r2_bm, 14);
        r3_ap <= r2_ap;
        r3_ah <= r2_ah;
        r4_temp <= esc_pkg::asr(r3_tf * 32'd5 + 32'd128, 8);
        r4_pa   <= esc_pkg::asr(r3_tf, 1) - esc_pkg::C_P_OFS;
        r4_hv   <= r3_tf - esc_pkg::C_H_OFS;
        r4_ap   <= r3_ap;
        r4_ah   <= r3_ah;
        // Products of the fine-temperature terms.
        r5_sq   <= w_q * w_q;
        r5_ap5  <= r4_pa * i_cal.p5;
        r5_p2a  <= i_cal.p2 * r4_pa;
        r5_h5hv <= i_cal.h5 * r4_hv;
        r5_h6hv <= r4_hv * i_cal.h6;
        r5_h3hv <= r4_hv * i_cal.h3;
        r5_temp <= r4_temp;
        r5_ap   <= r4_ap;
        r5_ah   <= r4_ah;
        r6_b1   <= esc_pkg::asr(r5_sq, 11) * i_cal.p6;
        r6_p3s  <= i_cal.p3 * esc_pkg::asr(r5_sq, 13);
        r6_x    <= esc_pkg::asr((({16'd0, r5_ah} << 14) - (i_cal.h4 << 20) - r5_h5hv)
                                + esc_pkg::C_H_RND14, 15);
        r6_hv6  <= esc_pkg::asr(r5_h6hv, 10);
        r6_hv3  <= esc_pkg::asr(r5_h3hv, 11) + esc_pkg::C_P_ONE;
        r6_ap5  <= r5_ap5;
        r6_p2a  <= r5_p2a;
        r6_temp <= r5_temp;
        r6_ap   <= r5_ap;
        r7_b    <= esc_pkg::asr(r6_b1 + (r6_ap5 << 1), 2) + (i_cal.p4 << 16);
        r7_a2   <= esc_pkg::asr(esc_pkg::asr(r6_p3s, 3) + esc_pkg::asr(r6_p2a, 1), 18);
        r7_y1   <= r6_hv6 * r6_hv3;
        r7_x    <= r6_x;
        r7_temp <= r6_temp;
        r7_ap   <= r6_ap;
        // Pressure divisor and numerator, humidity scale.
        r8_a3   <= (esc_pkg::C_P_ONE + r7_a2) * i_cal.p1;
        r8_pn   <= ((esc_pkg::C_P_BASE - {12'd0, r7_ap}) - esc_pkg::asr(r7_b, 12))
                   * esc_pkg::C_P_SCALE;
        r8_y3   <= (esc_pkg::asr(r7_y1, 10) + esc_pkg::C_H_BIAS) * i_cal.h2;
        r8_x    <= r7_x;
        r8_temp <= r7_temp;
        r9_div  <= esc_pkg::asr(r8_a3, 15);
        r9_pn   <= r8_pn;
        r9_hvm  <= r8_x * esc_pkg::asr(r8_y3 + esc_pkg::C_H_RND13, 14);
        r9_temp <= r8_temp;
        r10_ss  <= esc_pkg::asr(r9_hvm, 15) * esc_pkg::asr(r9_hvm, 15);
        r10_hvm <= r9_hvm;
        r10_div <= r9_div;
        r10_pn  <= r9_pn;
        r10_temp <= r9_temp;
        r11_h1m <= esc_pkg::asr(r10_ss, 7) * i_cal.h1;
        r11_hvm <= r10_hvm;
        r11_div <= r10_div;
        r11_pn  <= r10_pn;
        r11_temp <= r10_temp;
        // A numerator with its top bit set is divided first and doubled after.
        r12_ent.temp <= r11_temp;
        r12_ent.dvd  <= r11_pn[31] ? r11_pn : (r11_pn << 1);
        r12_ent.dbl  <= r11_pn[31];
        r12_ent.dvs  <= r11_div;
        r12_ent.zero <= (r11_div == '0);
        r12_ent.hum  <= w_hsc[23:10];
    end

    assign o_push      = r_v[esc_pkg::FRONT_STAGES-1];
    assign o_push_data = r12_ent;

    `ESC_ASSERT_IMP(a_push_has_credit, i_clk, i_rst_n, o_push, r_used != '0)
    `ESC_ASSERT_IMP(a_credit_bound, i_clk, i_rst_n, 1'b1,
                    r_used <= esc_pkg::QCNT_W'(esc_pkg::QDEPTH))

endmodule

>>> sv/esc_queue.sv
// Short queue between the front and back ends of the compensation block.
// Depends on esc_pkg; uses assert_macros.svh.
`include "assert_macros.svh"

module esc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  esc_pkg::t_qent i_data,
    input  logic           i_pop,
    output esc_pkg::t_qent o_data,
    output logic           o_empty
);

    esc_pkg::t_qent             r_mem [esc_pkg::QDEPTH];
    esc_pkg::t_qent             r_head;
    logic [esc_pkg::QPTR_W-1:0] r_wr, r_rd, n_rd;
    logic [esc_pkg::QCNT_W-1:0] r_count;

    assign n_rd = i_pop ? r_rd + 1'b1 : r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The head entry is registered from the next read pointer; a beat written into the slot
    // that becomes the head is taken straight from the write data.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        r_head <= (i_push && (r_wr == n_rd)) ? i_data : r_mem[n_rd];
    end

    assign o_data  = r_head;
    assign o_empty = (r_count == '0);

    `ESC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push,
                    (r_count != esc_pkg::QCNT_W'(esc_pkg::QDEPTH)) || i_pop)
    `ESC_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

>>> sv/esc_back.sv
// Back end: pipelined pressure division, final pressure correction and the
// result register. Depends on esc_pkg and esc_if; uses assert_macros.svh.
`include "assert_macros.svh"

module esc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  esc_pkg::t_cal  i_cal,
    input  esc_pkg::t_qent i_data,
    input  logic           i_empty,
    output logic           o_pop,
    esc_out_if.source      o_out
);

    localparam int NS = esc_pkg::DIV_STEPS + 1;

    logic        r_en_v [NS];
    logic [31:0] r_rem  [NS];
    logic [31:0] r_quo  [NS];
    logic [31:0] r_dvd  [NS];
    logic [31:0] r_dvs  [NS];
    logic        r_dbl  [NS];
    logic        r_zero [NS];
    esc_pkg::t_pay r_pay [NS];

    logic [32:0] w_trial [esc_pkg::DIV_STEPS];
    logic        w_ge    [esc_pkg::DIV_STEPS];

    logic        r_p1_v, r_p2_v, r_out_v;
    logic [31:0] r_p1_p, r_p1_xx, r_p1_c2m, r_p2_p, r_p2_c1m, r_p2_c2m;
    logic        r_p1_zero, r_p2_zero;
    esc_pkg::t_pay r_p1_pay, r_p2_pay;
    logic [31:0] w_p, w_corr;
    logic [31:0] r_press, r_temp;
    logic [13:0] r_hum;
    logic        w_en;

    // The whole back end moves as one while the result register can move.
    assign w_en  = !r_out_v || o_out.ready;
    assign o_pop = w_en && !i_empty;

    always_comb begin
        for (int k = 0; k < esc_pkg::DIV_STEPS; k++) begin
            w_trial[k] = {r_rem[k], r_dvd[k][31]};
            w_ge[k]    = (w_trial[k] >= {1'b0, r_dvs[k]});
        end
        w_p    = r_dbl[NS-1] ? (r_quo[NS-1] << 1) : r_quo[NS-1];
        w_corr = esc_pkg::asr(esc_pkg::asr(r_p2_c1m, 12) + esc_pkg::asr(r_p2_c2m, 13)
                              + i_cal.p7, 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_en_v[k] <= 1'b0;
            end
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_en_v[0] <= o_pop;
            for (int k = 1; k < NS; k++) begin
                r_en_v[k] <= r_en_v[k-1];
            end
            r_p1_v  <= r_en_v[NS-1];
            r_p2_v  <= r_p1_v;
            r_out_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem[0]  <= '0;
            r_quo[0]  <= '0;
            r_dvd[0]  <= i_data.dvd;
            r_dvs[0]  <= i_data.dvs;
            r_dbl[0]  <= i_data.dbl;
            r_zero[0] <= i_data.zero;
            r_pay[0]  <= '{hum: i_data.hum, temp: i_data.temp};
            // One quotient bit per step, restoring division.
            for (int k = 0; k < esc_pkg::DIV_STEPS; k++) begin
                r_rem[k+1]  <= w_ge[k] ? 32'(w_trial[k] - {1'b0, r_dvs[k]})
                                       : w_trial[k][31:0];
                r_quo[k+1]  <= {r_quo[k][30:0], w_ge[k]};
                r_dvd[k+1]  <= r_dvd[k] << 1;
                r_dvs[k+1]  <= r_dvs[k];
                r_dbl[k+1]  <= r_dbl[k];
                r_zero[k+1] <= r_zero[k];
                r_pay[k+1]  <= r_pay[k];
            end
            r_p1_p    <= w_p;
            r_p1_xx   <= (w_p >> 3) * (w_p >> 3);
            r_p1_c2m  <= (w_p >> 2) * i_cal.p8;
            r_p1_zero <= r_zero[NS-1];
            r_p1_pay  <= r_pay[NS-1];
            r_p2_p    <= r_p1_p;
            r_p2_c1m  <= i_cal.p9 * (r_p1_xx >> 13);
            r_p2_c2m  <= r_p1_c2m;
            r_p2_zero <= r_p1_zero;
            r_p2_pay  <= r_p1_pay;
            r_press   <= r_p2_zero ? '0 : r_p2_p + w_corr;
            r_temp    <= r_p2_pay.temp;
            r_hum     <= r_p2_pay.hum;
        end
    end

    assign o_out.valid     = r_out_v;
    assign o_out.temp_cdeg = $signed(r_temp);
    assign o_out.press_pa  = r_press;
    assign o_out.hum_crh   = r_hum;

    `ESC_ASSERT_NXT(a_hold_on_stall, i_clk, i_rst_n, !w_en,
                    $stable(r_p1_v) && $stable(r_p2_v) && $stable(r_out_v))
    `ESC_ASSERT_IMP(a_pop_moves, i_clk, i_rst_n, o_pop, w_en && !i_empty)

endmodule

>>> sv/env_sensor_compensation.sv
// Top level of the environmental sensor compensation block.
// Depends on esc_pkg, esc_if, esc_front, esc_queue and esc_back.
//
//  channel   | dir | handshake     | beat contents
//  ----------+-----+---------------+------------------------------------------
//  i_in      | in  | valid/ready   | raw_temp, raw_press, raw_hum
//  o_out     | out | valid/ready   | temp_cdeg, press_pa, hum_crh
//  i_cfg_*   | in  | write enable  | register index, 64-bit data
//
//  One beat is taken every cycle while results are taken; a beat passes 13 front
//  stages, the queue, 33 division stages and three correction stages.
//  The 32-step pressure divider, one quotient bit per stage, sets the latency.
//  Reset is synchronous and active low; it clears the calibration registers.
//  A stalled output freezes the back end; the front keeps running and its beats
//  wait in the 16-entry queue, input ready falling once all slots are owed.

module env_sensor_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    esc_in_if.sink      i_in,
    esc_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    // Packed calibration registers; the user must write them only while the block is idle (not enforced here).
    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_pa, r_cal_pb, r_cal_hum;
    logic [15:0] r_cal_pc;

    esc_pkg::t_cal  w_cal;
    esc_pkg::t_qent w_push_data, w_pop_data;
    logic           w_push, w_pop, w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp <= '0;
            r_cal_pa   <= '0;
            r_cal_pb   <= '0;
            r_cal_pc   <= '0;
            r_cal_hum  <= '0;
        end else if (i_cfg_we) begin
            // Writes to an index beyond the register list are dropped.
            case (esc_pkg::t_reg_idx'(i_cfg_idx))
                esc_pkg::REG_CAL_TEMP:    r_cal_temp <= i_cfg_data[47:0];
                esc_pkg::REG_CAL_PRESS_A: r_cal_pa   <= i_cfg_data;
                esc_pkg::REG_CAL_PRESS_B: r_cal_pb   <= i_cfg_data;
                esc_pkg::REG_CAL_PRESS_C: r_cal_pc   <= i_cfg_data[15:0];
                esc_pkg::REG_CAL_HUM:     r_cal_hum  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Unpack the coefficients; signed fields are sign-extended to 32 bits so
    // that every product below wraps exactly as 32-bit arithmetic does.
    always_comb begin
        w_cal.t1 = {16'd0, r_cal_temp[15:0]};
        w_cal.t2 = esc_pkg::sx16(r_cal_temp[31:16]);
        w_cal.t3 = esc_pkg::sx16(r_cal_temp[47:32]);
        w_cal.p1 = {16'd0, r_cal_pa[15:0]};
        w_cal.p2 = esc_pkg::sx16(r_cal_pa[31:16]);
        w_cal.p3 = esc_pkg::sx16(r_cal_pa[47:32]);
        w_cal.p4 = esc_pkg::sx16(r_cal_pa[63:48]);
        w_cal.p5 = esc_pkg::sx16(r_cal_pb[15:0]);
        w_cal.p6 = esc_pkg::sx16(r_cal_pb[31:16]);
        w_cal.p7 = esc_pkg::sx16(r_cal_pb[47:32]);
        w_cal.p8 = esc_pkg::sx16(r_cal_pb[63:48]);
        w_cal.p9 = esc_pkg::sx16(r_cal_pc);
        w_cal.h1 = {24'd0, r_cal_hum[7:0]};
        w_cal.h2 = esc_pkg::sx16(r_cal_hum[23:8]);
        w_cal.h3 = {24'd0, r_cal_hum[31:24]};
        w_cal.h4 = esc_pkg::sx12(r_cal_hum[43:32]);
        w_cal.h5 = esc_pkg::sx12(r_cal_hum[55:44]);
        w_cal.h6 = esc_pkg::sx8(r_cal_hum[63:56]);
    end

    // The front end computes temperature and humidity outright and prepares
    // the pressure division; the back end divides and finishes pressure.
    esc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cal       (w_cal),
        .i_pop       (w_pop),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    esc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_empty (w_empty)
    );

    esc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (w_cal),
        .i_data  (w_pop_data),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for env_sensor_compensation.
// Depends on esc_pkg and the esc_in_if / esc_out_if channel interfaces of the RTL.
module tb_top;

    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 300;
    // An index with no register behind it; writes to it must be ignored.
    localparam logic [2:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } t_raw;

    typedef struct packed {
        logic signed [31:0] temp_cdeg;
        logic        [31:0] press_pa;
        logic        [13:0] hum_crh;
    } t_comp;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    esc_in_if  in_ch();
    esc_out_if out_ch();

    env_sensor_compensation u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the calibration registers, as the block should hold them.
    logic [47:0] cal_temp_sh;
    logic [63:0] cal_pa_sh, cal_pb_sh, cal_hum_sh;
    logic [15:0] cal_pc_sh;

    t_raw  raw_pending[$];    // conversions waiting to be offered
    t_comp comp_expected[$];  // compensated results still owed by the block
    int    n_errors;
    bit    beat_taken;        // input beat accepted at the last rising edge
    bit    idle_on;           // random idling of both sides enabled
    bit    hold_request;      // asks the receiver for one long hold-off
    int    hold_left;

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    // Arithmetic right shift of a 32-bit two's complement word.
    function automatic logic [31:0] sar32(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    // Integer compensation of one conversion triple with the shadow calibration.
    // All intermediates wrap modulo 2^32, exactly as 32-bit hardware would.
    function automatic t_comp compensate(input t_raw r);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] at, ap, ah, a, b, d, q, sq, fine, p, x, y, s, hv, c1, c2;
        t_comp res;
        t1 = {16'b0, cal_temp_sh[15:0]};
        t2 = {{16{cal_temp_sh[31]}}, cal_temp_sh[31:16]};
        t3 = {{16{cal_temp_sh[47]}}, cal_temp_sh[47:32]};
        p1 = {16'b0, cal_pa_sh[15:0]};
        p2 = {{16{cal_pa_sh[31]}}, cal_pa_sh[31:16]};
        p3 = {{16{cal_pa_sh[47]}}, cal_pa_sh[47:32]};
        p4 = {{16{cal_pa_sh[63]}}, cal_pa_sh[63:48]};
        p5 = {{16{cal_pb_sh[15]}}, cal_pb_sh[15:0]};
        p6 = {{16{cal_pb_sh[31]}}, cal_pb_sh[31:16]};
        p7 = {{16{cal_pb_sh[47]}}, cal_pb_sh[47:32]};
        p8 = {{16{cal_pb_sh[63]}}, cal_pb_sh[63:48]};
        p9 = {{16{cal_pc_sh[15]}}, cal_pc_sh};
        h1 = {24'b0, cal_hum_sh[7:0]};
        h2 = {{16{cal_hum_sh[23]}}, cal_hum_sh[23:8]};
        h3 = {24'b0, cal_hum_sh[31:24]};
        h4 = {{20{cal_hum_sh[43]}}, cal_hum_sh[43:32]};
        h5 = {{20{cal_hum_sh[55]}}, cal_hum_sh[55:44]};
        h6 = {{24{cal_hum_sh[63]}}, cal_hum_sh[63:56]};
        at = {12'b0, r.raw_temp};
        ap = {12'b0, r.raw_press};
        ah = {16'b0, r.raw_hum};

        // Temperature, and the fine-temperature term shared by the others.
        a = sar32(((at >> 3) - (t1 << 1)) * t2, 11);
        d = (at >> 4) - t1;
        b = sar32(sar32(d * d, 12) * t3, 14);
        fine = a + b;
        res.temp_cdeg = sar32(fine * 32'd5 + 32'd128, 8);

        // Pressure.
        a = sar32(fine, 1) - 32'd64000;
        q = sar32(a, 2);
        sq = q * q;
        b = sar32(sq, 11) * p6;
        b = b + ((a * p5) << 1);
        b = sar32(b, 2) + (p4 << 16);
        a = sar32(sar32(p3 * sar32(sq, 13), 3) + sar32(p2 * a, 1), 18);
        a = sar32((32'd32768 + a) * p1, 15);
        if (a == 32'd0) begin
            res.press_pa = 32'd0;
        end else begin
            p = ((32'd1048576 - ap) - sar32(b, 12)) * 32'd3125;
            // A numerator with the top bit set is divided before doubling.
            if (p < 32'h8000_0000) begin
                p = (p << 1) / a;
            end else begin
                p = (p / a) * 32'd2;
            end
            x = p >> 3;
            c1 = sar32(p9 * ((x * x) >> 13), 12);
            c2 = sar32((p >> 2) * p8, 13);
            res.press_pa = p + sar32(c1 + c2 + p7, 4);
        end

        // Humidity, clamped to 0..100 %RH before rounding.
        hv = fine - 32'd76800;
        x = sar32(((ah << 14) - (h4 << 20) - (h5 * hv)) + 32'd16384, 15);
        y = sar32(hv * h6, 10) * (sar32(hv * h3, 11) + 32'd32768);
        y = sar32(y, 10) + 32'd2097152;
        y = sar32(y * h2 + 32'd8192, 14);
        hv = x * y;
        s = sar32(hv, 15);
        hv = hv - sar32(sar32(s * s, 7) * h1, 4);
        if (hv[31]) begin
            hv = 32'd0;
        end
        if (hv > 32'd419430400) begin
            hv = 32'd419430400;
        end
        hv = hv >> 12;
        res.hum_crh = 14'((hv * 32'd100 + 32'd512) / 32'd1024);
        return res;
    endfunction

    // Input side: record accepted beats and predict their results.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            comp_expected.push_back(compensate(raw_pending.pop_front()));
            beat_taken = 1'b1;
        end
    end

    // Driver: a beat stays on the bus until it is taken; gaps come at random.
    always @(negedge i_clk) begin
        if (!in_ch.valid || beat_taken) begin
            beat_taken = 1'b0;
            if (raw_pending.size() > 0 && !(idle_on && $urandom_range(99) < 10)) begin
                in_ch.valid     <= 1'b1;
                in_ch.raw_temp  <= raw_pending[0].raw_temp;
                in_ch.raw_press <= raw_pending[0].raw_press;
                in_ch.raw_hum   <= raw_pending[0].raw_hum;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request, so that the
    // internal queue fills and the block has to stall its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !(idle_on && $urandom_range(99) < 10);
        end
    end

    // Monitor: each result beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_comp want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (comp_expected.size() == 0) begin
                $error("result beat with no conversion outstanding");
                n_errors++;
            end else begin
                want = comp_expected.pop_front();
                if (out_ch.temp_cdeg !== want.temp_cdeg) begin
                    $error("temp_cdeg: expected %0d, got %0d",
                           want.temp_cdeg, out_ch.temp_cdeg);
                    n_errors++;
                end
                if (out_ch.press_pa !== want.press_pa) begin
                    $error("press_pa: expected %0d, got %0d", want.press_pa, out_ch.press_pa);
                    n_errors++;
                end
                if (out_ch.hum_crh !== want.hum_crh) begin
                    $error("hum_crh: expected %0d, got %0d", want.hum_crh, out_ch.hum_crh);
                    n_errors++;
                end
            end
        end
    end

    // Register write while the block is idle; the shadow follows the same rules.
    task automatic write_cal(input logic [2:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            esc_pkg::REG_CAL_TEMP:    cal_temp_sh = data[47:0];
            esc_pkg::REG_CAL_PRESS_A: cal_pa_sh   = data;
            esc_pkg::REG_CAL_PRESS_B: cal_pb_sh   = data;
            esc_pkg::REG_CAL_PRESS_C: cal_pc_sh   = data[15:0];
            esc_pkg::REG_CAL_HUM:     cal_hum_sh  = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [47:0] kt, input logic [63:0] ka, input logic [63:0] kb,
                             input logic [15:0] kc, input logic [63:0] kh);
        write_cal(esc_pkg::REG_CAL_TEMP, {16'b0, kt});
        write_cal(esc_pkg::REG_CAL_PRESS_A, ka);
        write_cal(esc_pkg::REG_CAL_PRESS_B, kb);
        write_cal(esc_pkg::REG_CAL_PRESS_C, {48'b0, kc});
        write_cal(esc_pkg::REG_CAL_HUM, kh);
    endtask

    // The sender pauses here until every owed result has come back.
    task automatic drain;
        wait (raw_pending.size() == 0 && comp_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic offer(input logic [19:0] rt, input logic [19:0] rp, input logic [15:0] rh);
        t_raw r;
        r.raw_temp  = rt;
        r.raw_press = rp;
        r.raw_hum   = rh;
        raw_pending.push_back(r);
    endtask

    // A conversion near a room reading (three in four if plausible), else fully random.
    task automatic offer_random(input bit plausible);
        if (plausible && $urandom_range(3) != 0) begin
            offer(20'($urandom_range(560000, 440000)), 20'($urandom_range(600000, 250000)),
                  16'($urandom_range(45000, 15000)));
        end else begin
            offer(20'($urandom), 20'($urandom), 16'($urandom));
        end
    endtask

    // Typical factory calibration, slightly perturbed when asked.
    task automatic write_typical(input bit jitter);
        logic [15:0] dt;
        dt = jitter ? 16'($urandom_range(2000)) : 16'd0;
        write_all({16'hFC18, 16'd26435, 16'd27504 + dt},
                  {16'd2855, 16'd3024, 16'hD643, 16'd36477 - dt},
                  {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                  16'd6000,
                  {8'd30, 12'd0, 12'd324, 8'd0, 16'd362, 8'd75});
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.raw_temp  = '0;
        in_ch.raw_press = '0;
        in_ch.raw_hum   = '0;
        out_ch.ready    = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = esc_pkg::REG_CAL_TEMP;
        i_cfg_data      = '0;
        cal_temp_sh = '0;
        cal_pa_sh   = '0;
        cal_pb_sh   = '0;
        cal_pc_sh   = '0;
        cal_hum_sh  = '0;
        n_errors     = 0;
        beat_taken   = 1'b0;
        idle_on      = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        i_rst_n      = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Calibration at reset: all zero, so the pressure divisor is zero.
        offer(20'd0, 20'd0, 16'd0);
        offer(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        offer(20'd519888, 20'd415148, 16'd27000);
        drain();

        // Typical calibration; an unmapped index must change nothing.
        write_typical(1'b0);
        write_cal(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        offer(20'd519888, 20'd415148, 16'd27000);
        offer(20'd0, 20'd0, 16'd0);             // very small raw pressure: large numerator
        offer(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        offer(20'd519888, 20'd415148, 16'hFFFF); // humidity clamped at the top
        offer(20'd519888, 20'd415148, 16'd0);    // humidity clamped at zero
        offer(20'd400000, 20'd300000, 16'd20000);
        offer(20'd600000, 20'd600000, 16'd40000);
        drain();

        // Extreme coefficients, both ends.
        write_all({48{1'b1}}, {64{1'b1}}, {64{1'b1}}, 16'h8000, {64{1'b1}});
        offer(20'd0, 20'd0, 16'd0);
        offer(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        offer(20'h80000, 20'h7FFFF, 16'h8000);
        drain();
        write_all({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                  {4{16'h7FFF}}, 16'h7FFF,
                  {8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF});
        offer(20'd0, 20'd0, 16'd0);
        offer(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        offer(20'd519888, 20'd415148, 16'd27000);
        drain();

        // Random phases. The first runs with no idling at all; the third holds
        // the receiver off for a long stretch while beats keep coming.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph % 2 == 0) begin
                write_typical(1'b1);
            end else begin
                write_all(48'({$urandom, $urandom}), {$urandom, $urandom},
                          {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
            end
            idle_on = (ph != 0);
            if (ph == 2) begin
                hold_request = 1'b1;
            end
            for (int k = 0; k < 115; k++) begin
                offer_random(ph % 2 == 0);
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a stuck handshake.
    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
